// ===== sv/etfi_pkg.sv =====
// Shared types and constants for the escape-time fractal iterator.
// Holds the sequencer state type, the mode codes, the register indexes and the fixed widths.
// No dependencies.
package etfi_pkg;

    localparam int DATA_W    = 32;
    localparam int OPND_W    = DATA_W + 1;
    localparam int PROD_W    = 64;
    localparam int FRAC_BITS = 28;
    localparam int SQ_SHIFT  = FRAC_BITS + 2;
    localparam int ITER_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRACTAL_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_C_RE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_C_IM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_SQ    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONVERGE_SQ  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd5;

    localparam logic [DATA_W-1:0] ESCAPE_SQ_RST = 32'h1000_0000;
    localparam logic [ITER_W-1:0] MAX_ITER_RST  = 16'd256;

    localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [1:0] {
        MODE_MANDEL = 2'd0,
        MODE_JULIA  = 2'd1,
        MODE_SHIP   = 2'd2,
        MODE_HOLD   = 2'd3
    } etfi_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_RR,
        ST_MUL_II,
        ST_MUL_RI,
        ST_UPDATE
    } etfi_state_t;

endpackage

// ===== sv/etfi_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on etfi_pkg for operand and product widths.
module etfi_mul
    import etfi_pkg::*;
(
    input  logic                     clk,
    input  logic signed [OPND_W-1:0] a,
    input  logic signed [OPND_W-1:0] b,
    output logic signed [PROD_W-1:0] p
);

    logic signed [2*OPND_W-1:0] prod_full;
    logic signed [PROD_W-1:0]   p_reg;

    // Operands never exceed 2^31 in magnitude, so the product fits in 64 bits.
    assign prod_full = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= prod_full[PROD_W-1:0];
    end

    assign p = p_reg;

endmodule

// ===== sv/escape_time_fractal_iterator_top.sv =====
// Top level of the escape-time fractal iterator: configuration registers, sequencer, update path.
// Depends on etfi_pkg and on etfi_mul, the one multiplier shared by all products.
//
// Write start with a point z0 (start_re, start_im, signed Q4.28) in a cycle where busy is low,
// and the beat is taken at that clock edge. The block then iterates z, starting from z0, with
// one 33x33 multiplier that is used three times per update: re*re, im*im and then re*im (or
// their absolute values in Burning Ship mode). Each update passes through the multiply states
// MUL_RR, MUL_II and MUL_RI, with the magnitude test in MUL_RI, and then UPDATE, which writes
// back the new z. A point that escapes or converges finishes from MUL_RI, one that runs to the
// limit finishes from UPDATE, and with max_iter zero the result follows in the next
// cycle. The result beat appears on iter_count, stayed_bounded, final_re and final_im for exactly
// one cycle, marked by done; the receiver cannot stall it, so it must capture it then. busy is
// already low while done is high, so the next point may be started in that same cycle. The
// configuration registers are written through cfg_we, cfg_index and cfg_wdata, and should only
// be written while busy is low; indexes six and seven are ignored.
module escape_time_fractal_iterator_top
    import etfi_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]           cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [DATA_W-1:0]    start_re,
    input  logic signed [DATA_W-1:0]    start_im,
    output logic                        done,
    output logic [ITER_W-1:0]           iter_count,
    output logic                        stayed_bounded,
    output logic signed [DATA_W-1:0]    final_re,
    output logic signed [DATA_W-1:0]    final_im
);

    // Configuration registers.
    etfi_mode_t                 fractal_mode_reg;
    logic signed [DATA_W-1:0]   julia_c_re_reg;
    logic signed [DATA_W-1:0]   julia_c_im_reg;
    logic [DATA_W-1:0]          escape_sq_reg;
    logic [DATA_W-1:0]          converge_sq_reg;
    logic [ITER_W-1:0]          max_iter_reg;

    // Sequencer and datapath registers.
    etfi_state_t                state_reg, state_next;
    logic signed [DATA_W-1:0]   zr_reg, zr_next;
    logic signed [DATA_W-1:0]   zi_reg, zi_next;
    logic signed [DATA_W-1:0]   ar_reg, ar_next;
    logic signed [DATA_W-1:0]   ai_reg, ai_next;
    logic signed [PROD_W-1:0]   p_rr_reg, p_rr_next;
    logic signed [PROD_W-1:0]   p_ii_reg, p_ii_next;
    logic [ITER_W-1:0]          k_reg, k_next;
    logic                       bounded_reg, bounded_next;
    logic                       done_reg, done_next;

    // Multiplier operands and product.
    logic signed [OPND_W-1:0]   zr_ext, zi_ext, zr_abs, zi_abs;
    logic signed [OPND_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]   mul_p;

    // Magnitude test and update arithmetic.
    logic [PROD_W-1:0]          mag_sum;
    logic [DATA_W-1:0]          mag;
    logic                       mag_ovf;
    logic signed [PROD_W-1:0]   sq_diff;
    logic signed [PROD_W-1:0]   ar_wide, ai_wide;
    logic signed [PROD_W-1:0]   re_wide, im_wide;
    logic [ITER_W-1:0]          k_inc;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[DATA_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[DATA_W-1:0];
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Configuration writes. The mode register keeps the low two bits of the data word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fractal_mode_reg <= MODE_MANDEL;
            julia_c_re_reg   <= '0;
            julia_c_im_reg   <= '0;
            escape_sq_reg    <= ESCAPE_SQ_RST;
            converge_sq_reg  <= '0;
            max_iter_reg     <= MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRACTAL_MODE: fractal_mode_reg <= etfi_mode_t'(cfg_wdata[1:0]);
                REG_JULIA_C_RE:   julia_c_re_reg   <= cfg_wdata;
                REG_JULIA_C_IM:   julia_c_im_reg   <= cfg_wdata;
                REG_ESCAPE_SQ:    escape_sq_reg    <= cfg_wdata;
                REG_CONVERGE_SQ:  converge_sq_reg  <= cfg_wdata;
                REG_MAX_ITER:     max_iter_reg     <= cfg_wdata[ITER_W-1:0];
                default:          ;
            endcase
        end
    end

    // Operand selection for the shared multiplier. The squares do not depend on sign, so
    // only the cross product needs the absolute values in Burning Ship mode.
    assign zr_ext = {zr_reg[DATA_W-1], zr_reg};
    assign zi_ext = {zi_reg[DATA_W-1], zi_reg};
    assign zr_abs = zr_reg[DATA_W-1] ? -zr_ext : zr_ext;
    assign zi_abs = zi_reg[DATA_W-1] ? -zi_ext : zi_ext;

    always_comb
    begin
        case (state_reg)
            ST_MUL_RR:
            begin
                mul_a = zr_ext;
                mul_b = zr_ext;
            end
            ST_MUL_II:
            begin
                mul_a = zi_ext;
                mul_b = zi_ext;
            end
            default:
            begin
                mul_a = (fractal_mode_reg == MODE_SHIP) ? zr_abs : zr_ext;
                mul_b = (fractal_mode_reg == MODE_SHIP) ? zi_abs : zi_ext;
            end
        endcase
    end

    etfi_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // In the MUL_RI cycle the multiplier output holds im^2 and p_rr_reg holds re^2.
    // Both squares are non-negative and at most 2^63 together, so the sum is exact.
    assign mag_sum = $unsigned(p_rr_reg) + $unsigned(mul_p);
    assign mag_ovf = |mag_sum[PROD_W-1:SQ_SHIFT+DATA_W];
    assign mag     = mag_sum[SQ_SHIFT+DATA_W-1:SQ_SHIFT];

    // In the UPDATE cycle the multiplier output holds the cross product.
    // Arithmetic right shifts give the floor of the scaled products.
    assign sq_diff = p_rr_reg - p_ii_reg;
    assign ar_wide = {{(PROD_W-DATA_W){ar_reg[DATA_W-1]}}, ar_reg};
    assign ai_wide = {{(PROD_W-DATA_W){ai_reg[DATA_W-1]}}, ai_reg};
    assign re_wide = (sq_diff >>> FRAC_BITS) + ar_wide;
    assign im_wide = (mul_p >>> (FRAC_BITS - 1)) + ai_wide;
    assign k_inc   = k_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            k_reg       <= '0;
            bounded_reg <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            k_reg       <= k_next;
            bounded_reg <= bounded_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        ar_reg   <= ar_next;
        ai_reg   <= ai_next;
        p_rr_reg <= p_rr_next;
        p_ii_reg <= p_ii_next;
    end

    // Sequencer: one pass through MUL_RR, MUL_II, MUL_RI and UPDATE per iteration.
    always_comb
    begin
        state_next   = state_reg;
        zr_next      = zr_reg;
        zi_next      = zi_reg;
        ar_next      = ar_reg;
        ai_next      = ai_reg;
        p_rr_next    = p_rr_reg;
        p_ii_next    = p_ii_reg;
        k_next       = k_reg;
        bounded_next = bounded_reg;
        done_next    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    zr_next      = start_re;
                    zi_next      = start_im;
                    k_next       = '0;
                    bounded_next = 1'b1;
                    if (fractal_mode_reg == MODE_JULIA)
                    begin
                        ar_next = julia_c_re_reg;
                        ai_next = julia_c_im_reg;
                    end
                    else
                    begin
                        ar_next = start_re;
                        ai_next = start_im;
                    end
                    // With a zero limit no check runs and z0 comes back unchanged.
                    if (max_iter_reg == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_MUL_RR;
                    end
                end
            end
            ST_MUL_RR:
            begin
                state_next = ST_MUL_II;
            end
            ST_MUL_II:
            begin
                p_rr_next  = mul_p;
                state_next = ST_MUL_RI;
            end
            ST_MUL_RI:
            begin
                p_ii_next = mul_p;
                if (mag_ovf || (mag > escape_sq_reg))
                begin
                    bounded_next = 1'b0;
                    done_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (mag < converge_sq_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (fractal_mode_reg != MODE_HOLD)
                begin
                    zr_next = sat32(re_wide);
                    zi_next = sat32(im_wide);
                end
                k_next = k_inc;
                if (k_inc == max_iter_reg)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MUL_RR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign iter_count     = k_reg;
    assign stayed_bounded = bounded_reg;
    assign final_re       = zr_reg;
    assign final_im       = zi_reg;

`ifndef SYNTH
    // An accepted point either starts the sequencer or, with a zero limit, finishes at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
    else $error("accepted point neither started nor finished");

    // A result beat only appears once the sequencer has let go.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
    else $error("result beat shown while busy");

    // The update count never passes the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (iter_count <= max_iter_reg))
    else $error("iteration count above limit");

    // An escaped point always stopped before the limit was used up.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !stayed_bounded) |-> (iter_count < max_iter_reg))
    else $error("escape reported at the limit");

    // The square states MUL_RR and MUL_II always run back to back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL_RR) |=> (state_reg == ST_MUL_II))
    else $error("square sequence broken");
`endif

endmodule

// ===== dv/etfi_orbit_checker.sv =====
`timescale 1ns / 100ps
// Orbit checker for the escape-time fractal iterator: predicts each point's escape count,
// bounded flag and final z from its own copy of the registers and compares every result beat.
// Depends on etfi_pkg for the widths, register indexes, mode codes and reset values.
module etfi_orbit_checker
    import etfi_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]           cfg_wdata,
    input  logic                        start,
    input  logic                        busy,
    input  logic signed [DATA_W-1:0]    start_re,
    input  logic signed [DATA_W-1:0]    start_im,
    input  logic                        done,
    input  logic [ITER_W-1:0]           iter_count,
    input  logic                        stayed_bounded,
    input  logic signed [DATA_W-1:0]    final_re,
    input  logic signed [DATA_W-1:0]    final_im,
    output int                          mismatches,
    output int                          orbits_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [ITER_W-1:0]          count;
        logic                       bounded;
        logic signed [DATA_W-1:0]   re;
        logic signed [DATA_W-1:0]   im;
    } orbit_end_t;

    etfi_mode_t                 mode_q;
    logic signed [DATA_W-1:0]   c_re_q;
    logic signed [DATA_W-1:0]   c_im_q;
    logic [DATA_W-1:0]          escape_q;
    logic [DATA_W-1:0]          converge_q;
    logic [ITER_W-1:0]          limit_q;

    orbit_end_t                 expected_ends[$];
    orbit_end_t                 want;
    int                         bad_count;
    int                         beat_count;

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > SAT_MAX)
            return SAT_MAX;
        if (v < SAT_MIN)
            return SAT_MIN;
        return v;
    endfunction

    // Runs the whole orbit of one starting point under the current register settings.
    function automatic orbit_end_t trace_orbit(input logic signed [DATA_W-1:0] z0_re,
                                               input logic signed [DATA_W-1:0] z0_im);
        longint      zr;
        longint      zi;
        longint      add_re;
        longint      add_im;
        longint      a;
        longint      b;
        logic [63:0] mr;
        logic [63:0] mi;
        logic [63:0] mag;
        int          k;
        orbit_end_t  res;
        zr = z0_re;
        zi = z0_im;
        if (mode_q == MODE_JULIA)
        begin
            add_re = c_re_q;
            add_im = c_im_q;
        end
        else
        begin
            add_re = zr;
            add_im = zi;
        end
        res.bounded = 1'b1;
        for (k = 0; k < int'(limit_q); k++)
        begin
            mr  = magnitude(zr);
            mi  = magnitude(zi);
            mag = (mr * mr + mi * mi) >> SQ_SHIFT;
            // A square that no longer fits in 32 bits counts as an escape.
            if (mag > 64'h0000_0000_FFFF_FFFF || mag > 64'(escape_q))
            begin
                res.bounded = 1'b0;
                break;
            end
            if (mag < 64'(converge_q))
                break;
            if (mode_q == MODE_HOLD)
                continue;
            a = zr;
            b = zi;
            if (mode_q == MODE_SHIP)
            begin
                a = longint'(magnitude(zr));
                b = longint'(magnitude(zi));
            end
            zr = clamp32(((a * a - b * b) >>> FRAC_BITS) + add_re);
            zi = clamp32(((a * b) >>> (FRAC_BITS - 1)) + add_im);
        end
        res.count = k[ITER_W-1:0];
        res.re    = zr[DATA_W-1:0];
        res.im    = zi[DATA_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q     = MODE_MANDEL;
            c_re_q     = '0;
            c_im_q     = '0;
            escape_q   = ESCAPE_SQ_RST;
            converge_q = '0;
            limit_q    = MAX_ITER_RST;
            expected_ends.delete();
            bad_count  = 0;
            beat_count = 0;
            mismatches     <= 0;
            orbits_pending <= 0;
        end
        else
        begin
            // Results leave first, so a beat finishing and a new point starting on the same
            // edge keep their order.
            if (done)
            begin
                if (expected_ends.size() == 0)
                begin
                    if (bad_count < REPORT_LIMIT)
                        $display("orbit check: beat %0d arrived with no point in flight",
                                 beat_count);
                    bad_count++;
                end
                else
                begin
                    want = expected_ends.pop_front();
                    if (iter_count !== want.count || stayed_bounded !== want.bounded ||
                        final_re !== want.re || final_im !== want.im)
                    begin
                        if (bad_count < REPORT_LIMIT)
                            $display("orbit check: beat %0d want %0d/%0b (%h,%h) got %0d/%0b (%h,%h)",
                                     beat_count, want.count, want.bounded, want.re, want.im,
                                     iter_count, stayed_bounded, final_re, final_im);
                        bad_count++;
                    end
                end
                beat_count++;
            end
            if (start && !busy)
                expected_ends.push_back(trace_orbit(start_re, start_im));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRACTAL_MODE: mode_q     = etfi_mode_t'(cfg_wdata[1:0]);
                    REG_JULIA_C_RE:   c_re_q     = cfg_wdata;
                    REG_JULIA_C_IM:   c_im_q     = cfg_wdata;
                    REG_ESCAPE_SQ:    escape_q   = cfg_wdata;
                    REG_CONVERGE_SQ:  converge_q = cfg_wdata;
                    REG_MAX_ITER:     limit_q    = cfg_wdata[ITER_W-1:0];
                    default:          ;
                endcase
            end
            mismatches     <= bad_count;
            orbits_pending <= expected_ends.size();
        end
    end

endmodule

// ===== dv/tb_escape_time_fractal_iterator_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the escape-time fractal iterator: clock, reset, register programming,
// point stimulus and the verdict. Depends on etfi_pkg, the block and etfi_orbit_checker.
module tb_escape_time_fractal_iterator_top;
    import etfi_pkg::*;

    // The longest correct quiet stretch is one point running 65535 updates plus a sender gap;
    // the watchdog allows several times that.
    localparam int WATCHDOG_LIMIT = 1_200_000;
    // Every point produces exactly one result, so the block is idle once the last expected
    // beat has come; SETTLE_CYCLES is only a margin before touching the registers.
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 16;

    // Indexes six and seven are unused; writes there must leave every register alone.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam logic [DATA_W-1:0] Q_MIN        = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_MAX        = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_LSB_NEG    = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] Q_LSB        = 32'h0000_0001;
    localparam logic [DATA_W-1:0] SQ_FULL      = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] SQ_SIXTEENTH = 32'h0040_0000;

    // Kinds of starting point: inside or near the Mandelbrot set, raw random bits,
    // just right of the cusp at 0.25 where escapes take many updates, and tiny points
    // that fall under a convergence threshold at once.
    typedef enum logic [1:0] {
        PT_NEAR,
        PT_NOISE,
        PT_SLOW,
        PT_TINY
    } point_kind_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [DATA_W-1:0]          cfg_wdata;
    logic                       start;
    logic                       busy;
    logic signed [DATA_W-1:0]   start_re;
    logic signed [DATA_W-1:0]   start_im;
    logic                       done;
    logic [ITER_W-1:0]          iter_count;
    logic                       stayed_bounded;
    logic signed [DATA_W-1:0]   final_re;
    logic signed [DATA_W-1:0]   final_im;
    int                         mismatch_count;
    int                         orbits_pending;

    escape_time_fractal_iterator_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .start_re       (start_re),
        .start_im       (start_im),
        .done           (done),
        .iter_count     (iter_count),
        .stayed_bounded (stayed_bounded),
        .final_re       (final_re),
        .final_im       (final_im)
    );

    // The checker sits beside the block on the same wires; it owns prediction and
    // comparison and only hands back how many beats went wrong and how many are owed.
    etfi_orbit_checker orbit_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .start_re       (start_re),
        .start_im       (start_im),
        .done           (done),
        .iter_count     (iter_count),
        .stayed_bounded (stayed_bounded),
        .final_re       (final_re),
        .final_im       (final_im),
        .mismatches     (mismatch_count),
        .orbits_pending (orbits_pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Converts a real value to signed Q4.28, truncating toward zero.
    function automatic logic [DATA_W-1:0] q4_28(input real v);
        return DATA_W'($rtoi(v * 268435456.0));
    endfunction

    // One register write per clock edge. The write enable stays high between back-to-back
    // writes and is dropped by close_regs, so it never gets two assignments in one step.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic close_regs();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_all(input etfi_mode_t mode, input logic [DATA_W-1:0] c_re,
                               input logic [DATA_W-1:0] c_im, input logic [DATA_W-1:0] esc,
                               input logic [DATA_W-1:0] conv, input logic [ITER_W-1:0] lim);
        set_reg(REG_FRACTAL_MODE, DATA_W'(mode));
        set_reg(REG_JULIA_C_RE, c_re);
        set_reg(REG_JULIA_C_IM, c_im);
        set_reg(REG_ESCAPE_SQ, esc);
        set_reg(REG_CONVERGE_SQ, conv);
        set_reg(REG_MAX_ITER, DATA_W'(lim));
        close_regs();
    endtask

    // Registers may only change while no point is in flight. The pending count is updated
    // at the edge that takes a point, so the next edge passes before it is looked at.
    task automatic wait_idle();
        @(posedge clk);
        while (orbits_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offers one point and returns at the edge that takes the beat. Before the offer the
    // sender may sit idle for a random stretch, one coin flip per cycle, so gaps land on
    // every state of the block's update.
    task automatic send_point(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im,
                              input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        start_re <= re;
        start_im <= im;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pick_point(input point_kind_t kind, output logic [DATA_W-1:0] re,
                              output logic [DATA_W-1:0] im);
        case (kind)
            PT_NEAR:
            begin
                // Real part in [-2, 0.5], imaginary part in [-1.2, 1.2].
                re = DATA_W'($urandom_range(671088640)) - q4_28(2.0);
                im = DATA_W'($urandom_range(644245094)) - 32'd322122547;
            end
            PT_SLOW:
            begin
                re = q4_28(0.26) + DATA_W'($urandom_range(13421772));
                im = DATA_W'($urandom_range(2684354)) - 32'd1342177;
            end
            PT_TINY:
            begin
                re = DATA_W'($urandom_range(26843545)) - 32'd13421772;
                im = DATA_W'($urandom_range(26843545)) - 32'd13421772;
            end
            default:
            begin
                re = $urandom;
                im = $urandom;
            end
        endcase
    endtask

    // A run of points of one kind, with some raw random points mixed in.
    task automatic run_points(input int count, input int idle_pct, input point_kind_t kind,
                              input int noise_pct);
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        for (int i = 0; i < count; i++)
        begin
            pick_point(($urandom_range(99) < noise_pct) ? PT_NOISE : kind, re, im);
            send_point(re, im, idle_pct);
        end
        start <= 1'b0;
    endtask

    // Watchdog: ends the run if neither a point nor a result beat moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_escape_time_fractal_iterator_top: done, errors");
        $finish;
    end

    initial
    begin
        etfi_mode_t        rnd_mode;
        logic [DATA_W-1:0] rnd_c_re;
        logic [DATA_W-1:0] rnd_c_im;
        logic [DATA_W-1:0] rnd_esc;
        logic [DATA_W-1:0] rnd_conv;
        int                rnd_idle;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        start     = 1'b0;
        start_re  = '0;
        start_im  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings are left untouched here: Mandelbrot, escape at 4, no early stop,
        // 256 updates. The origin and the lowest bit below zero never move and run to the
        // limit; -1 cycles with period two; -2 sits exactly on the escape threshold;
        // 0.25 is the cusp and 0.3 escapes after a long crawl; the corners overflow.
        send_point('0, '0, 0);
        send_point(Q_LSB_NEG, Q_LSB_NEG, 0);
        send_point(q4_28(-1.0), '0, 0);
        send_point(q4_28(-2.0), '0, 0);
        send_point(q4_28(0.25), '0, 0);
        send_point(q4_28(0.3), '0, 0);
        send_point(Q_MIN, Q_MIN, 0);
        send_point(Q_MAX, Q_MAX, 0);
        start <= 1'b0;
        wait_idle();

        // Widest escape square with a zero limit: no check runs at all, so every point,
        // even one whose square overflows, comes back unchanged and bounded.
        program_all(MODE_MANDEL, '0, '0, SQ_FULL, '0, '0);
        send_point(Q_MIN, Q_MIN, 0);
        send_point(Q_MAX, '0, 0);
        send_point(q4_28(1.0), q4_28(1.0), 0);
        send_point('0, '0, 0);
        start <= 1'b0;
        wait_idle();

        // Hold mode with a zero escape square: any nonzero square escapes at once, while a
        // point whose square truncates to zero runs to the limit unchanged.
        program_all(MODE_HOLD, '0, '0, '0, '0, 16'd5);
        send_point('0, '0, 0);
        send_point(Q_LSB, '0, 0);
        send_point(q4_28(0.01), '0, 0);
        start <= 1'b0;
        wait_idle();

        // Hold mode with both thresholds at their top: every square below the top converges.
        program_all(MODE_HOLD, '0, '0, SQ_FULL, SQ_FULL, 16'd5);
        send_point(q4_28(2.0), q4_28(-2.0), 0);
        send_point(Q_MIN, Q_MIN, 0);
        start <= 1'b0;
        wait_idle();

        // Julia with a classic constant, then with the constant at both extremes.
        program_all(MODE_JULIA, q4_28(-0.8), q4_28(0.156), ESCAPE_SQ_RST, '0, 16'd64);
        send_point('0, '0, 0);
        send_point(q4_28(0.3), q4_28(-0.4), 0);
        send_point(q4_28(1.5), q4_28(1.5), 0);
        start <= 1'b0;
        wait_idle();
        program_all(MODE_JULIA, Q_MIN, Q_MAX, SQ_FULL, '0, 16'd64);
        send_point('0, '0, 0);
        send_point(q4_28(-0.5), q4_28(0.5), 0);
        start <= 1'b0;
        wait_idle();

        // Burning Ship, with writes to the unused indexes in between that must change nothing.
        program_all(MODE_SHIP, '0, '0, ESCAPE_SQ_RST, '0, 16'd32);
        set_reg(REG_SPARE_6, SQ_FULL);
        set_reg(REG_SPARE_7, SQ_FULL);
        close_regs();
        send_point(q4_28(-1.75), q4_28(-0.03), 0);
        send_point(q4_28(0.5), q4_28(-0.5), 0);
        send_point(q4_28(-1.6), '0, 0);
        start <= 1'b0;
        wait_idle();

        // Random part. Most points lie in or near the set so that orbits run long; a share
        // of raw random bits keeps every input bit moving and hits saturation.
        program_all(MODE_MANDEL, '0, '0, ESCAPE_SQ_RST, '0, 16'd64);
        run_points(120, 0, PT_NEAR, 10);
        wait_idle();

        program_all(MODE_JULIA, q4_28(-0.70176), q4_28(-0.3842), ESCAPE_SQ_RST,
                    SQ_SIXTEENTH, 16'd128);
        run_points(110, 55, PT_NEAR, 15);
        wait_idle();

        program_all(MODE_SHIP, '0, '0, ESCAPE_SQ_RST, '0, 16'd100);
        run_points(100, 22, PT_NEAR, 15);
        wait_idle();

        program_all(MODE_HOLD, '0, '0, $urandom, DATA_W'($urandom_range(268435456)), 16'd16);
        run_points(60, 55, PT_NEAR, 40);
        wait_idle();

        // An escape square of nearly 64 lets orbits grow until the update saturates.
        program_all(MODE_MANDEL, '0, '0, SQ_FULL, '0, 16'd200);
        run_points(60, 22, PT_NEAR, 20);
        wait_idle();

        program_all(MODE_JULIA, $urandom, $urandom, $urandom, '0, 16'd24);
        run_points(60, 0, PT_NOISE, 0);
        wait_idle();

        // The largest limit, with points that escape slowly and tiny points that converge at once,
        // with some raw random points mixed in among the tiny ones.
        program_all(MODE_MANDEL, '0, '0, ESCAPE_SQ_RST, SQ_SIXTEENTH, 16'hFFFF);
        run_points(20, 0, PT_SLOW, 0);
        run_points(20, 55, PT_TINY, 10);
        wait_idle();

        // Short phases with every register drawn at random, limits kept small.
        for (int p = 0; p < 6; p++)
        begin
            rnd_mode = etfi_mode_t'($urandom_range(3));
            if ($urandom_range(1) == 0)
            begin
                rnd_c_re = DATA_W'($urandom_range(536870912)) - q4_28(1.0);
                rnd_c_im = DATA_W'($urandom_range(536870912)) - q4_28(1.0);
            end
            else
            begin
                rnd_c_re = $urandom;
                rnd_c_im = $urandom;
            end
            case ($urandom_range(3))
                0:       rnd_esc = '0;
                1:       rnd_esc = $urandom;
                2:       rnd_esc = SQ_FULL;
                default: rnd_esc = ESCAPE_SQ_RST;
            endcase
            case ($urandom_range(2))
                0:       rnd_conv = '0;
                1:       rnd_conv = DATA_W'($urandom_range(32'h0100_0000));
                default: rnd_conv = $urandom;
            endcase
            rnd_idle = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 55 : 22);
            program_all(rnd_mode, rnd_c_re, rnd_c_im, rnd_esc, rnd_conv,
                        ITER_W'($urandom_range(48)));
            run_points(20, rnd_idle, PT_NEAR, 25);
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && orbits_pending == 0)
            $display("tb_escape_time_fractal_iterator_top: done, clean");
        else
            $display("tb_escape_time_fractal_iterator_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
sv/etfi_pkg.sv
sv/etfi_mul.sv
sv/escape_time_fractal_iterator_top.sv
dv/etfi_orbit_checker.sv
dv/tb_escape_time_fractal_iterator_top.sv
